// File: rtl/iir_direct_form_one_filter_unit_assert.svh
// assertion macros for the direct form one filter unit
`ifndef IIR_DIRECT_FORM_ONE_FILTER_UNIT_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define IIRDF1_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition that must never hold outside reset
`define IIRDF1_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define IIRDF1_CHECK(label, prop, msg)
`define IIRDF1_NEVER(label, cond, msg)
`endif

`endif

// File: rtl/iirdf1_pkg.sv
package iirdf1_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 24;
   localparam int FRAC_BITS = 20;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int SUM_W    = PROD_W + 3;
   localparam int QUOT_W   = SUM_W + 1 - FRAC_BITS;

   // tap count defaults
   localparam int FEEDFORWARD_TAPS_DEF = 3;
   localparam int FEEDBACK_TAPS_DEF    = 3;

   // register map
   localparam int REG_COUNT   = 6;
   localparam int REG_INDEX_W = 3;
   localparam logic [REG_INDEX_W-1:0] REG_INPUT_GAIN = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_B0    = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_B1    = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_B2    = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_A1    = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_COEF_A2    = 3'd5;

   // reset values, 1.0 in Q4.20
   localparam logic signed [COEF_W-1:0] COEF_ONE  = 24'sd1048576;
   localparam logic signed [COEF_W-1:0] COEF_ZERO = 24'sd0;

   localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MULT,
      ST_ACC,
      ST_DONE
   } state_type;

   // strobes from the sequencer to the tap cells
   typedef struct packed {
      logic load_head;
      logic shift;
   } cell_ctrl_type;

   // round half up from Q.20, then saturate to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] round_sat16(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W:0]    r;
      logic signed [QUOT_W-1:0] q;
      logic                     fits;
      r = $signed({v[SUM_W-1], v}) + ROUND_HALF;
      q = r[SUM_W:FRAC_BITS];
      fits = (&q[QUOT_W-1:SAMPLE_W-1]) || !(|q[QUOT_W-1:SAMPLE_W-1]);
      if (fits) begin
         round_sat16 = q[SAMPLE_W-1:0];
      end else if (q[QUOT_W-1]) begin
         round_sat16 = SAMPLE_MIN;
      end else begin
         round_sat16 = SAMPLE_MAX;
      end
   endfunction

endpackage

// File: rtl/iirdf1_tap_cell.sv
module iirdf1_tap_cell
   import iirdf1_pkg::*;
#(
   parameter bit HEAD     = 1'b0,
   parameter bit SUBTRACT = 1'b0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctrl_type              ctrl,
   input  logic signed [COEF_W-1:0]   coef,
   input  logic signed [SAMPLE_W-1:0] sample_next,
   input  logic signed [SUM_W-1:0]    sum_prev,
   output logic signed [SAMPLE_W-1:0] sample_held,
   output logic signed [SUM_W-1:0]    sum_next
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       load;

   // history sample, taken from the neighbor or from the head source
   assign load = HEAD ? ctrl.load_head : ctrl.shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (load) begin
         sample_ff <= sample_next;
      end
   end

   // tap product, then add into the partial sum passed along the row
   assign prod_in = coef * sample_ff;
   assign sum_in  = SUBTRACT ? (sum_prev - SUM_W'(prod_ff))
                             : (sum_prev + SUM_W'(prod_ff));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sample_held = sample_ff;
   assign sum_next    = sum_ff;

endmodule

// File: rtl/iir_direct_form_one_filter_unit.sv
// Direct form I biquad on signed 16-bit samples. A sample is scaled by input_gain,
// rounded half up and saturated, then y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
// (Q4.20 coefficients, 1.0 = 1048576) is rounded once and saturated to 16 bits.
// Each tap is a cell holding one history sample and its coefficient product; the
// partial sum walks the row one cell per cycle. The result sits in an output
// register, and the next sample is taken while it waits; when that next result is
// ready and the register is still full, the block holds in its last step until the
// pending beat is taken and the register has emptied. Histories clear at reset; csr
// writes are meant for idle time only, and indexes past the register list are
// ignored.
`include "iir_direct_form_one_filter_unit_assert.svh"

module iir_direct_form_one_filter_unit
   import iirdf1_pkg::*;
#(
   parameter int FEEDFORWARD_TAPS = FEEDFORWARD_TAPS_DEF,
   parameter int FEEDBACK_TAPS    = FEEDBACK_TAPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [REG_INDEX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]          csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   localparam int NCELL = FEEDFORWARD_TAPS + FEEDBACK_TAPS - 1;
   localparam int CNT_W = (NCELL > 1) ? $clog2(NCELL) : 1;

   logic signed [COEF_W-1:0]   coef_ff [REG_COUNT];
   logic signed [PROD_W-1:0]   gain_prod_ff;
   logic signed [SAMPLE_W-1:0] x_scaled, y_new;
   logic signed [SAMPLE_W-1:0] out_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]           acc_cnt_ff, acc_cnt_in;
   state_type                  state_ff, state_in;
   cell_ctrl_type              ctrl;
   logic                       out_load, req_beat, rsp_beat;

   logic signed [SAMPLE_W-1:0] cell_sample [NCELL];
   logic signed [SUM_W-1:0]    cell_sum    [NCELL];

   // configuration registers
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_INPUT_GAIN] <= COEF_ONE;
         coef_ff[REG_COEF_B0]    <= COEF_ONE;
         coef_ff[REG_COEF_B1]    <= COEF_ZERO;
         coef_ff[REG_COEF_B2]    <= COEF_ZERO;
         coef_ff[REG_COEF_A1]    <= COEF_ZERO;
         coef_ff[REG_COEF_A2]    <= COEF_ZERO;
      end else if (csr_valid) begin
         case (csr_index)
            REG_INPUT_GAIN: coef_ff[REG_INPUT_GAIN] <= csr_wdata;
            REG_COEF_B0:    coef_ff[REG_COEF_B0]    <= csr_wdata;
            REG_COEF_B1:    coef_ff[REG_COEF_B1]    <= csr_wdata;
            REG_COEF_B2:    coef_ff[REG_COEF_B2]    <= csr_wdata;
            REG_COEF_A1:    coef_ff[REG_COEF_A1]    <= csr_wdata;
            REG_COEF_A2:    coef_ff[REG_COEF_A2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid_ff && rsp_ready;

   // input gain product, taken on the request beat
   always_ff @(posedge clock) begin
      if (req_beat) begin
         gain_prod_ff <= coef_ff[REG_INPUT_GAIN] * req_sample_in;
      end
   end

   assign x_scaled = round_sat16(SUM_W'(gain_prod_ff));
   assign y_new    = round_sat16(cell_sum[NCELL-1]);

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      acc_cnt_in = acc_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_MULT;
         ST_MULT: begin
            state_in   = ST_ACC;
            acc_cnt_in = '0;
         end
         ST_ACC: begin
            if (acc_cnt_ff == CNT_W'(NCELL - 1)) begin
               state_in = ST_DONE;
            end else begin
               acc_cnt_in = acc_cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) state_in = req_valid ? ST_SCALE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      out_load       = 1'b0;
      ctrl.load_head = 1'b0;
      ctrl.shift     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = !reset;
         ST_SCALE: ctrl.load_head = 1'b1;
         ST_MULT:  ;
         ST_ACC:   ;
         ST_DONE: begin
            req_ready  = !rsp_valid_ff;
            out_load   = !rsp_valid_ff;
            ctrl.shift = !rsp_valid_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         acc_cnt_ff <= acc_cnt_in;
      end
   end

   // output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= y_new;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   // row of tap cells: feedforward cells first, then feedback cells
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      localparam bit IS_FB   = (k >= FEEDFORWARD_TAPS);
      localparam int REG_IDX = IS_FB ? (int'(REG_COEF_A1) + k - FEEDFORWARD_TAPS)
                                     : (int'(REG_COEF_B0) + k);
      logic signed [SAMPLE_W-1:0] sample_src;
      logic signed [SUM_W-1:0]    sum_src;

      if (k == 0) begin : g_head
         assign sample_src = x_scaled;
         assign sum_src    = '0;
      end else if (k == FEEDFORWARD_TAPS) begin : g_fb_head
         assign sample_src = y_new;
         assign sum_src    = cell_sum[k-1];
      end else begin : g_body
         assign sample_src = cell_sample[k-1];
         assign sum_src    = cell_sum[k-1];
      end

      iirdf1_tap_cell #(
         .HEAD     (k == 0),
         .SUBTRACT (IS_FB)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .coef        (coef_ff[REG_INDEX_W'(REG_IDX)]),
         .sample_next (sample_src),
         .sum_prev    (sum_src),
         .sample_held (cell_sample[k]),
         .sum_next    (cell_sum[k])
      );
   end

   // checks
   `IIRDF1_CHECK(a_beat_starts_scale, req_beat |=> (state_ff == ST_SCALE),
                 "request beat did not start the scale step")
   `IIRDF1_CHECK(a_rsp_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE),
                 "response raised outside the done step")
   `IIRDF1_CHECK(a_hold_pending, (state_ff == ST_DONE && rsp_valid_ff) |=> (state_ff == ST_DONE),
                 "left done step while a result was still pending")
   `IIRDF1_NEVER(a_cnt_range, (state_ff == ST_ACC) && (acc_cnt_ff > CNT_W'(NCELL - 1)),
                 "accumulate count past the last cell")

endmodule

// File: tb/iir_direct_form_one_filter_unit_tb.sv
`timescale 1ns / 1ps

module iir_direct_form_one_filter_unit_tb
   import iirdf1_pkg::*;
();

   // register indexes that decode to nothing
   localparam logic [REG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [REG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam logic signed [COEF_W-1:0] GAIN_HALF = 24'sd524288;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_SAMPLES = 50;
   localparam int DRAIN_CYCLES = 20;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [REG_INDEX_W-1:0]     csr_index = '0;
   logic [COEF_W-1:0]          csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;

   // filter state mirrored on the testbench side
   logic signed [COEF_W-1:0]   coef_bank [REG_COUNT];
   logic signed [SAMPLE_W-1:0] x_hist [2];
   logic signed [SAMPLE_W-1:0] y_hist [2];

   logic signed [SAMPLE_W-1:0] filtered_q [$];
   int                         mismatch_count = 0;
   bit                         steady_flow = 1'b0;

   iir_direct_form_one_filter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   // round half up out of Q.20, then clamp to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] round_q20(input longint v);
      longint r;
      r = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > 32767) return SAMPLE_MAX;
      if (r < -32768) return SAMPLE_MIN;
      return r[SAMPLE_W-1:0];
   endfunction

   // one biquad step: scale the sample, run the difference equation, shift histories
   function automatic logic signed [SAMPLE_W-1:0] biquad_step(
      input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      longint acc;
      x = round_q20(longint'(coef_bank[REG_INPUT_GAIN]) * longint'(s));
      acc = longint'(coef_bank[REG_COEF_B0]) * longint'(x);
      acc += longint'(coef_bank[REG_COEF_B1]) * longint'(x_hist[0]);
      acc += longint'(coef_bank[REG_COEF_B2]) * longint'(x_hist[1]);
      acc -= longint'(coef_bank[REG_COEF_A1]) * longint'(y_hist[0]);
      acc -= longint'(coef_bank[REG_COEF_A2]) * longint'(y_hist[1]);
      y = round_q20(acc);
      x_hist[1] = x_hist[0];
      x_hist[0] = x;
      y_hist[1] = y_hist[0];
      y_hist[0] = y;
      return y;
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 20);
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            $error("sample_out: unexpected beat, got %0d", rsp_sample_out);
            mismatch_count++;
         end else begin
            logic signed [SAMPLE_W-1:0] want;
            want = filtered_q.pop_front();
            if (rsp_sample_out !== want) begin
               $error("sample_out: expected %0d, got %0d", want, rsp_sample_out);
               mismatch_count++;
            end
         end
      end
   end

   // random gap before a beat, none during a steady stretch
   task automatic idle_gap();
      int gap;
      if (!steady_flow && $urandom_range(99) < 20) begin
         gap = $urandom_range(1, 9);
         repeat (gap) @(negedge clock);
      end
   endtask

   // push one sample beat and record its predicted output
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      @(negedge clock);
      idle_gap();
      req_valid <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
      filtered_q.push_back(biquad_step(s));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // register write beat
   task automatic csr_write(input logic [REG_INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
      @(negedge clock);
      idle_gap();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < REG_COUNT) coef_bank[idx] = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every predicted output has come back
   task automatic wait_drained();
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_coefs(input logic [COEF_W-1:0] gain, input logic [COEF_W-1:0] b0,
                             input logic [COEF_W-1:0] b1, input logic [COEF_W-1:0] b2,
                             input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2);
      wait_drained();
      csr_write(REG_INPUT_GAIN, gain);
      csr_write(REG_COEF_B0, b0);
      csr_write(REG_COEF_B1, b1);
      csr_write(REG_COEF_B2, b2);
      csr_write(REG_COEF_A1, a1);
      csr_write(REG_COEF_A2, a2);
   endtask

   // random coefficient, mostly within +/-1.0, sometimes full range
   function automatic logic [COEF_W-1:0] pick_coef(input bit full_range);
      int v;
      if (full_range) v = $urandom;
      else v = int'($urandom_range(0, 2 * 1048576)) - 1048576;
      return v[COEF_W-1:0];
   endfunction

   // random sample, mostly full range, sometimes near zero
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int v;
      if ($urandom_range(99) < 25) v = int'($urandom_range(0, 512)) - 256;
      else v = $urandom;
      return v[SAMPLE_W-1:0];
   endfunction

   // reset values give a unity pass-through
   task automatic test_reset_passthrough();
      send_sample(16'sd0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sh5555);
      send_sample(16'shaaaa);
   endtask

   // input gain: half-up ties and saturation at the upper limit from both gain signs
   task automatic test_gain_rounding();
      load_coefs(GAIN_HALF, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd3);
      send_sample(-16'sd3);
      load_coefs(24'h7fffff, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
      send_sample(SAMPLE_MAX);
      load_coefs(24'h800000, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
      send_sample(SAMPLE_MIN);
   endtask

   // difference of delayed inputs, b1 = 1.0 and b2 = -1.0
   task automatic test_feedforward_taps();
      load_coefs(COEF_ONE, COEF_ZERO, COEF_ONE, -COEF_ONE, COEF_ZERO, COEF_ZERO);
      send_sample(16'sd1000);
      send_sample(-16'sd2000);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
   endtask

   // integrator with extra feedback, runs into both rails
   task automatic test_feedback_saturation();
      load_coefs(COEF_ONE, COEF_ONE, COEF_ZERO, COEF_ZERO, -COEF_ONE, GAIN_HALF);
      send_sample(16'sd20000);
      send_sample(16'sd20000);
      send_sample(16'sd20000);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
   endtask

   // writes past the register list must change nothing
   task automatic test_spare_index();
      load_coefs(COEF_ONE, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff);
      csr_write(REG_SPARE_LO, 24'hffffff);
      csr_write(REG_SPARE_HI, 24'h000000);
      send_sample(16'sd123);
      send_sample(-16'sd77);
   endtask

   // random coefficient sets with random sample streams
   task automatic test_random_streams();
      bit full_range;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         full_range = (phase % 4 == 3);
         steady_flow = (phase == 5);
         wait_drained();
         if (phase == 8) begin
            load_coefs(24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000);
         end else begin
            load_coefs(pick_coef(full_range), pick_coef(full_range), pick_coef(full_range),
                       pick_coef(full_range), pick_coef(full_range), pick_coef(full_range));
         end
         if ($urandom_range(1)) begin
            csr_write(REG_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      COEF_W'($urandom));
         end
         for (int n = 0; n < PHASE_SAMPLES; n++) send_sample(pick_sample());
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      coef_bank[REG_INPUT_GAIN] = COEF_ONE;
      coef_bank[REG_COEF_B0] = COEF_ONE;
      coef_bank[REG_COEF_B1] = COEF_ZERO;
      coef_bank[REG_COEF_B2] = COEF_ZERO;
      coef_bank[REG_COEF_A1] = COEF_ZERO;
      coef_bank[REG_COEF_A2] = COEF_ZERO;
      x_hist[0] = '0;
      x_hist[1] = '0;
      y_hist[0] = '0;
      y_hist[1] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_gain_rounding();
      test_feedforward_taps();
      test_feedback_saturation();
      test_spare_index();
      test_random_streams();

      // drain and settle
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && filtered_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/iirdf1_pkg.sv
rtl/iirdf1_tap_cell.sv
rtl/iir_direct_form_one_filter_unit.sv
tb/iir_direct_form_one_filter_unit_tb.sv
